// ===== rtl/hough_line_accumulator_defines.svh =====
// ----------------------------------------------------------------------------
// hough line accumulator assertion macros
// shared concurrent assertion forms for the accumulator rtl
// ----------------------------------------------------------------------------
`ifndef HOUGH_LINE_ACCUMULATOR_DEFINES_SVH
`define HOUGH_LINE_ACCUMULATOR_DEFINES_SVH

// check that is switched off while reset is asserted
`define HLA_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// check that also holds during reset
`define HLA_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/hla_pkg.sv =====
// ----------------------------------------------------------------------------
// hough line accumulator package
// shared types, constants and the q2.14 sine/cosine table
// ----------------------------------------------------------------------------
package hla_pkg;

	// fixed point layout of the rho sum
	localparam int FRAC_BITS  = 14;
	localparam int PROD_W     = 25;
	localparam int SUM_W      = 27;
	localparam int RHO_FULL_W = SUM_W - 1 - FRAC_BITS;

	localparam logic [11:0] COUNT_MAX = 12'hFFF;
	localparam logic [7:0]  DEG_LAST  = 8'd179;
	localparam logic [7:0]  DEG_RIGHT = 8'd90;

	// configuration registers
	localparam int          CFG_IDX_W          = 2;
	localparam logic [1:0]  REG_VOTE_THRESHOLD = 2'd0;
	localparam logic [1:0]  REG_RHO_OFFSET     = 2'd1;
	localparam logic [11:0] THRESH_RESET       = 12'd25;
	localparam logic [9:0]  OFFSET_RESET       = 10'd363;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_VOTE,
		ST_READ,
		ST_DRAIN
	} state_t;

	// one accumulator bin: count, first voter, latest voter
	typedef struct packed {
		logic [11:0] count;
		logic [15:0] first;
		logic [15:0] last;
	} bin_t;

	// work issued to the rho unit
	typedef struct packed {
		logic vote;
		logic read;
	} issue_t;

	// status coming back from the rho unit
	typedef struct packed {
		logic valid;
		logic is_read;
		logic hit;
		logic busy;
	} rho_req_t;

	// round(2^14 * sin(k degrees)), k = 0..90
	localparam logic [14:0] QSINE [0:90] = '{
		15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
		15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
		15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
		15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
		15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
		15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
		15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
		15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
		15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
		15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
		15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
		15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
		15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
		15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
		15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
		15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
		15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
		15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
		15'd16384
	};

	// sine for 0..179 degrees
	function automatic logic signed [15:0] sin_q14(input logic [7:0] deg);
		logic [7:0] k;
		if (deg <= DEG_RIGHT) begin
			k = deg;
		end else begin
			k = 8'd180 - deg;
		end
		sin_q14 = $signed({1'b0, QSINE[k[6:0]]});
	endfunction

	// cosine for 0..179 degrees, negative past a right angle
	function automatic logic signed [15:0] cos_q14(input logic [7:0] deg);
		logic [7:0] k;
		if (deg <= DEG_RIGHT) begin
			k = DEG_RIGHT - deg;
			cos_q14 = $signed({1'b0, QSINE[k[6:0]]});
		end else begin
			k = deg - DEG_RIGHT;
			cos_q14 = -$signed({1'b0, QSINE[k[6:0]]});
		end
	endfunction

endpackage

// ===== rtl/hough_line_accumulator.sv =====
// ----------------------------------------------------------------------------
// hough line accumulator
// rho/angle vote store with read-and-clear of single bins
// ----------------------------------------------------------------------------
// Usage:
//   input words (in_valid/in_stall) carry mode, pixel and bin fields. A mode 0
//   edge pixel inside the image votes in at most one bin per angle (none where
//   rho falls out of range); other mode 0 words are taken and change nothing.
//   A voting pixel holds the input while one angle enters the rho unit per
//   cycle, each angle does a read-modify-write of its bin, and the pipeline
//   drains before the next word is taken.
//   A mode 1 word reads one bin, clears it and puts one result word on the
//   output (out_valid/out_stall) once it has passed the rho unit and the
//   memory read stage; the block is ready again once the pipeline drains.
//   The output register holds its word while out_stall is high. Vote words
//   are still taken then; a further read word waits until the result leaves.
//   After reset the bin memory is swept to zero, one bin per cycle, over all
//   RHO_BINS * ANGLE_STEPS bins (184320 at the defaults); in_stall stays
//   high meanwhile and configuration writes are taken as usual.
// ----------------------------------------------------------------------------
`include "hough_line_accumulator_defines.svh"

module hough_line_accumulator #(
	parameter int IMAGE_ROWS  = 256,
	parameter int IMAGE_COLS  = 256,
	parameter int ANGLE_STEPS = 180,
	parameter int RHO_BINS    = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [hla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [11:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [7:0]                    pixel_row,
	input  logic [7:0]                    pixel_col,
	input  logic                          is_edge,
	input  logic [9:0]                    rho_bin,
	input  logic [7:0]                    angle_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [11:0]                   vote_count,
	output logic                          above_threshold,
	output logic [7:0]                    first_row,
	output logic [7:0]                    first_col,
	output logic [7:0]                    last_row,
	output logic [7:0]                    last_col
);
	import hla_pkg::*;

	localparam int BIN_COUNT = RHO_BINS * ANGLE_STEPS;
	localparam int ADDR_W    = $clog2(BIN_COUNT);
	localparam int ANG_W     = $clog2(ANGLE_STEPS);

	state_t            state_q, state_d;
	logic [11:0]       thr_q;
	logic [9:0]        offset_q;
	logic [7:0]        row_q, col_q, rd_ang_q;
	logic [9:0]        rd_rho_q;
	logic [ANG_W-1:0]  n_q;
	logic [7:0]        deg_q;
	logic [ADDR_W-1:0] clr_q;
	logic              accept, n_last, clr_last, in_image, clearing;
	issue_t            issue;
	rho_req_t          req;
	logic [ADDR_W-1:0] req_addr;

	bin_t              bin_mem_q [BIN_COUNT];
	bin_t              rd_data_s4;
	logic              v_s4, hit_s4, rd_s4;
	logic [ADDR_W-1:0] addr_s4;
	logic              rd_en, wr_en;
	logic [ADDR_W-1:0] wr_addr;
	bin_t              wr_data, upd;

	logic              out_valid_q;
	logic [11:0]       count_q;
	logic              above_q;
	logic [15:0]       first_q, last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THRESH_RESET;
			offset_q <= OFFSET_RESET;
		end else if (cfg_write) begin
			if (cfg_index == REG_VOTE_THRESHOLD) begin
				thr_q <= cfg_data;
			end
			if (cfg_index == REG_RHO_OFFSET) begin
				offset_q <= cfg_data[9:0];
			end
		end
	end

	assign n_last   = (n_q == ANG_W'(ANGLE_STEPS - 1));
	assign clr_last = (clr_q == ADDR_W'(BIN_COUNT - 1));
	assign in_image = (32'(pixel_row) < IMAGE_ROWS) && (32'(pixel_col) < IMAGE_COLS);

	// sequencer outputs
	always_comb begin
		in_stall   = (state_q != ST_IDLE) || (mode && out_valid_q);
		accept     = in_valid && !in_stall;
		issue.vote = (state_q == ST_VOTE);
		issue.read = (state_q == ST_READ);
		clearing   = (state_q == ST_CLEAR);
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (mode) begin
						state_d = ST_READ;
					end else if (is_edge && in_image) begin
						state_d = ST_VOTE;
					end
				end
			end
			ST_VOTE: begin
				if (n_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_READ: begin
				state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!(req.busy || req.valid || v_s4)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, angle and clear counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			n_q     <= '0;
			deg_q   <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				n_q   <= '0;
				deg_q <= '0;
			end else if (issue.vote) begin
				n_q   <= n_q + ANG_W'(1);
				deg_q <= (deg_q == DEG_LAST) ? 8'd0 : deg_q + 8'd1;
			end
			if (clearing) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
		end
	end

	// captured input word
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q    <= pixel_row;
			col_q    <= pixel_col;
			rd_rho_q <= rho_bin;
			rd_ang_q <= angle_index;
		end
	end

	hla_rho_unit #(
		.ANGLE_STEPS (ANGLE_STEPS),
		.RHO_BINS    (RHO_BINS)
	) u_rho (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.n      (n_q),
		.deg    (deg_q),
		.row    (row_q),
		.col    (col_q),
		.offset (offset_q),
		.rd_rho (rd_rho_q),
		.rd_ang (rd_ang_q),
		.req    (req),
		.addr   (req_addr)
	);

	// memory read stage
	assign rd_en = req.valid && req.hit;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s4 <= bin_mem_q[req_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		hit_s4  <= req.hit;
		rd_s4   <= req.is_read;
		addr_s4 <= req_addr;
	end

	// bin update: saturating count, first voter on an empty bin
	always_comb begin
		upd.count = (rd_data_s4.count == COUNT_MAX) ? COUNT_MAX : rd_data_s4.count + 12'd1;
		upd.first = (rd_data_s4.count == '0) ? {row_q, col_q} : rd_data_s4.first;
		upd.last  = {row_q, col_q};
	end

	// write port: clearing sweep, vote update or read-clear
	always_comb begin
		if (clearing) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = v_s4 && hit_s4;
			wr_addr = addr_s4;
			wr_data = rd_s4 ? '0 : upd;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bin_mem_q[wr_addr] <= wr_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (v_s4 && rd_s4) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && rd_s4) begin
			if (hit_s4) begin
				count_q <= rd_data_s4.count;
				above_q <= (rd_data_s4.count >= thr_q);
				first_q <= rd_data_s4.first;
				last_q  <= rd_data_s4.last;
			end else begin
				count_q <= '0;
				above_q <= 1'b0;
				first_q <= '0;
				last_q  <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign vote_count      = count_q;
	assign above_threshold = above_q;
	assign first_row       = first_q[15:8];
	assign first_col       = first_q[7:0];
	assign last_row        = last_q[15:8];
	assign last_col        = last_q[7:0];

	// checks
	`HLA_ASSERT_ALWAYS(a_clear_blocks_input, clk, (state_q == ST_CLEAR) |-> in_stall, "input taken during clearing sweep")
	`HLA_ASSERT(a_result_slot_free, clk, arst_n, (v_s4 && rd_s4) |-> !out_valid_q, "read result overwrites a waiting word")
	`HLA_ASSERT(a_rmw_no_overlap, clk, arst_n, (rd_en && wr_en) |-> (req_addr != wr_addr), "read and write hit the same bin")

endmodule

// ===== rtl/hla_rho_unit.sv =====
// ----------------------------------------------------------------------------
// hla rho unit
// shared pipelined unit: one angle per cycle, rho = row*cos + col*sin + bias,
// range check and bin address; read requests reuse the address multiplier
// ----------------------------------------------------------------------------
module hla_rho_unit #(
	parameter int ANGLE_STEPS = 180,
	parameter int RHO_BINS    = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  hla_pkg::issue_t                       issue,
	input  logic [$clog2(ANGLE_STEPS)-1:0]        n,
	input  logic [7:0]                            deg,
	input  logic [7:0]                            row,
	input  logic [7:0]                            col,
	input  logic [9:0]                            offset,
	input  logic [9:0]                            rd_rho,
	input  logic [7:0]                            rd_ang,
	output hla_pkg::rho_req_t                     req,
	output logic [$clog2(RHO_BINS*ANGLE_STEPS)-1:0] addr
);
	import hla_pkg::*;

	localparam int ANG_W  = $clog2(ANGLE_STEPS);
	localparam int ADDR_W = $clog2(RHO_BINS * ANGLE_STEPS);

	logic                      v_s1, v_s2, sel_rd_s2, rd_ok_s2;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [15:0]        sin_s1;
	logic [ANG_W-1:0]          n_s1, n_s2;
	logic signed [SUM_W-1:0]   sum_s2;
	logic [9:0]                rd_rho_s2;
	logic [7:0]                rd_ang_s2;
	logic                      valid_s3, is_read_s3, hit_s3;
	logic [ADDR_W-1:0]         addr_s3;
	logic [RHO_FULL_W-1:0]     rho_op;
	logic [ADDR_W-1:0]         ang_op;
	logic                      hit_c;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			v_s1     <= issue.vote;
			v_s2     <= v_s1 || issue.read;
			valid_s3 <= v_s2;
		end
	end

	// stage 1: table lookup and row*cos
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'($signed({1'b0, row}) * cos_q14(deg));
		sin_s1  <= sin_q14(deg);
		n_s1    <= n;
	end

	// stage 2: add col*sin and the bias, or take a read request
	always_ff @(posedge clk) begin
		sum_s2    <= SUM_W'($signed({1'b0, offset, {FRAC_BITS{1'b0}}}))
			+ SUM_W'(prod_s1) + SUM_W'($signed({1'b0, col}) * sin_s1);
		n_s2      <= n_s1;
		sel_rd_s2 <= issue.read;
		rd_rho_s2 <= rd_rho;
		rd_ang_s2 <= rd_ang;
		rd_ok_s2  <= (32'(rd_rho) < RHO_BINS) && (32'(rd_ang) < ANGLE_STEPS);
	end

	// stage 3 operands: floored rho or requested bin
	always_comb begin
		if (sel_rd_s2) begin
			rho_op = RHO_FULL_W'(rd_rho_s2);
			ang_op = ADDR_W'(rd_ang_s2);
			hit_c  = rd_ok_s2;
		end else begin
			rho_op = sum_s2[SUM_W-2:FRAC_BITS];
			ang_op = ADDR_W'(n_s2);
			hit_c  = !sum_s2[SUM_W-1] && (32'(rho_op) < RHO_BINS);
		end
	end

	// stage 3: bin address
	always_ff @(posedge clk) begin
		addr_s3    <= ADDR_W'(ADDR_W'(rho_op) * ADDR_W'(ANGLE_STEPS)) + ang_op;
		is_read_s3 <= sel_rd_s2;
		hit_s3     <= hit_c;
	end

	assign req.valid   = valid_s3;
	assign req.is_read = is_read_s3;
	assign req.hit     = hit_s3;
	assign req.busy    = v_s1 || v_s2;
	assign addr        = addr_s3;

endmodule
